@@ design/mpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mpq_pkg
// Operation and status codes shared by the priority queue modules.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int unsigned VAL_W = 32;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_VIEW = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_REMOVED = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_VIEW    = 3'd4
    } t_status;

endpackage

@@ design/mpq_ram.sv @@
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/mpq_max.sv @@
// ----------------------------------------------------------------------------
// mpq_max
// Shared running-maximum unit: one signed compare per enabled cycle, keeps the
// largest value seen and the slot it came from.
// ----------------------------------------------------------------------------
module mpq_max #(
    parameter int unsigned AW = 4
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_first,
    input  logic [mpq_pkg::VAL_W-1:0]   i_data,
    input  logic [AW-1:0]               i_idx,
    output logic [mpq_pkg::VAL_W-1:0]   o_best,
    output logic [AW-1:0]               o_best_idx
);

    logic [mpq_pkg::VAL_W-1:0] r_best;
    logic [AW-1:0]             r_best_idx;
    logic                      w_take;

    // strict greater keeps the earliest of equal maxima
    assign w_take = i_first || ($signed(i_data) > $signed(r_best));

    always_ff @(posedge i_clk) begin
        if (i_en && w_take) begin
            r_best     <= i_data;
            r_best_idx <= i_idx;
        end
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

@@ design/max_priority_queue_scan.sv @@
// ----------------------------------------------------------------------------
// max_priority_queue_scan
// Bounded max-priority queue kept as an unsorted list in a RAM.
//
// Input stream: s_axis_tuser carries the operation (enqueue, dequeue largest,
// view all), s_axis_tdata the value to enqueue. One operation is taken at a
// time; s_axis_tready is high only while the sequencer is idle.
// Output stream: m_axis_tuser carries the status, m_axis_tdata the value,
// m_axis_tlast marks the final result of an operation. View gives one result
// per stored entry, oldest first, or one empty result on an empty queue;
// enqueue and dequeue give one result each, and a no-op gives none.
// Dequeue is bound by the single RAM read port: one entry is read per
// cycle, first for the maximum scan, then to close the gap.
// A 1-entry output register decouples the sides; a stalled receiver holds
// the sequencer in its emit step without losing state.
// Reset empties the queue; RAM contents are left as they are.
// ----------------------------------------------------------------------------
module max_priority_queue_scan #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_res
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_EMPTY,
        S_SCAN,
        S_SDRAIN,
        S_SSET,
        S_SHIFT,
        S_DEQOUT,
        S_VRD,
        S_VOUT
    } t_state;

    t_state                    r_state;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_idx;
    logic [mpq_pkg::VAL_W-1:0] r_val;
    logic                      r_wr_pend;
    logic [AW-1:0]             r_wr_addr;
    logic                      r_cmp_vld;
    logic                      r_cmp_first;
    logic [AW-1:0]             r_cmp_idx;

    logic                      r_ovalid;
    mpq_pkg::t_status          r_ostatus;
    logic [mpq_pkg::VAL_W-1:0] r_oval;
    logic                      r_olast;

    logic                      w_out_free;
    logic                      w_emit;
    logic                      w_full;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [mpq_pkg::VAL_W-1:0] w_wdata;
    logic                      w_re;
    logic [mpq_pkg::VAL_W-1:0] w_rdata;
    logic [mpq_pkg::VAL_W-1:0] w_best;
    logic [AW-1:0]             w_best_idx;
    logic                      w_view_last;

    assign w_out_free  = !r_ovalid || m_axis_tready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_view_last = (r_idx == r_count - CW'(1));
    // a new result is loaded into the output register this cycle
    assign w_emit      = w_out_free && ((r_state == S_ENQ) || (r_state == S_EMPTY) ||
                                        (r_state == S_DEQOUT) || (r_state == S_VOUT));

    always_comb begin
        w_we    = r_wr_pend;
        w_waddr = r_wr_addr;
        w_wdata = w_rdata;
        w_re    = 1'b0;
        unique case (r_state)
            S_ENQ: begin
                if (w_out_free && !w_full) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[AW-1:0];
                    w_wdata = r_val;
                end
            end
            S_SCAN:  w_re = 1'b1;
            S_SHIFT: w_re = (r_idx < r_count);
            S_VRD:   w_re = 1'b1;
            default: w_re = 1'b0;
        endcase
    end

    mpq_ram #(
        .WIDTH (mpq_pkg::VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    mpq_max #(
        .AW (AW)
    ) u_max (
        .i_clk      (i_clk),
        .i_en       (r_cmp_vld),
        .i_first    (r_cmp_first),
        .i_data     (w_rdata),
        .i_idx      (r_cmp_idx),
        .o_best     (w_best),
        .o_best_idx (w_best_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_wr_pend <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (m_axis_tready && !w_emit) begin
                r_ovalid <= 1'b0;
            end
            r_wr_pend <= (r_state == S_SHIFT) && (r_idx < r_count);
            r_cmp_vld <= (r_state == S_SCAN);

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_val <= s_axis_tdata;
                        r_idx <= '0;
                        unique case (mpq_pkg::t_op'(s_axis_tuser))
                            mpq_pkg::OP_ENQ:  r_state <= S_ENQ;
                            mpq_pkg::OP_DEQ:  r_state <= (r_count == '0) ? S_EMPTY : S_SCAN;
                            mpq_pkg::OP_VIEW: r_state <= (r_count == '0) ? S_EMPTY : S_VRD;
                            mpq_pkg::OP_NONE: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ENQ: begin
                    if (w_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= w_full ? mpq_pkg::ST_FULL : mpq_pkg::ST_ADDED;
                        r_oval    <= r_val;
                        r_olast   <= 1'b1;
                        if (!w_full) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_EMPTY: begin
                    if (w_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= mpq_pkg::ST_EMPTY;
                        r_oval    <= '0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    // read issued now, compared next cycle
                    r_cmp_first <= (r_idx == '0);
                    r_cmp_idx   <= r_idx[AW-1:0];
                    r_idx       <= r_idx + CW'(1);
                    if (r_idx == r_count - CW'(1)) begin
                        r_state <= S_SDRAIN;
                    end
                end
                S_SDRAIN: r_state <= S_SSET;
                S_SSET: begin
                    r_idx   <= CW'(w_best_idx) + CW'(1);
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    // read slot idx, write it to idx-1 in the next cycle
                    if (r_idx < r_count) begin
                        r_wr_addr <= r_idx[AW-1:0] - AW'(1);
                        r_idx     <= r_idx + CW'(1);
                    end else begin
                        r_state <= S_DEQOUT;
                    end
                end
                S_DEQOUT: begin
                    if (w_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= mpq_pkg::ST_REMOVED;
                        r_oval    <= w_best;
                        r_olast   <= 1'b1;
                        r_count   <= r_count - CW'(1);
                        r_state   <= S_IDLE;
                    end
                end
                S_VRD: r_state <= S_VOUT;
                S_VOUT: begin
                    if (w_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= mpq_pkg::ST_VIEW;
                        r_oval    <= w_rdata;
                        r_olast   <= w_view_last;
                        r_idx     <= r_idx + CW'(1);
                        r_state   <= w_view_last ? S_IDLE : S_VRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oval;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tlast  = r_olast;

endmodule
